>>> src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> src/fdc_pkg.sv
package fdc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int SAMPLE_W   = 16;
  localparam int DELAY_W    = 20;

  // one-pole smoothing factor 0.999 in Q0.16
  localparam logic [16:0] SMOOTH_COEF = 17'd65470;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_TARGET  = 3'd0,
    REG_MAX_DELAY     = 3'd1,
    REG_FEEDBACK      = 3'd2,
    REG_FEEDBACK_LOW  = 3'd3,
    REG_FEEDBACK_HIGH = 3'd4,
    REG_COMB_NEGATIVE = 3'd5
  } reg_index_t;

  localparam logic [DELAY_W-1:0]  DELAY_TARGET_RST  = 20'd25600;
  localparam logic [DELAY_W-1:0]  MAX_DELAY_RST     = 20'd614400;
  localparam logic [SAMPLE_W-1:0] FEEDBACK_RST      = 16'h2000;
  localparam logic [SAMPLE_W-1:0] FEEDBACK_LOW_RST  = 16'hC000;
  localparam logic [SAMPLE_W-1:0] FEEDBACK_HIGH_RST = 16'h4000;

endpackage

>>> src/fractional_delay_comb_filter.sv
// Fractional-delay feedback comb filter, one audio sample per input beat.
// Input stream (s_*): each beat carries sample_in, delay_scale and
// feedback_mod. Output stream (m_*): one beat of sample_out per input beat,
// in order. Configuration: cfg_we writes cfg_data into the register chosen
// by cfg_index (delay target, max delay, feedback and its clamps, comb
// sign); write only while no sample is in flight. Unknown indexes are dropped.
// Timing: a small sequencer runs every sample through one shared 21x18
// signed multiplier (four products per sample) and a compare-subtract
// loop that folds the delay into the line span. s_tready is high only
// while the sequencer is idle, so a new sample is accepted only once the
// last one has been loaded into the output register. The delay line is a
// single-port-write, single-port-read RAM; its two interpolation taps are
// read on consecutive cycles.
// Reset (rst, synchronous): registers take their defaults, the line reads
// as zero until written (no clearing pass), and the first sample loads the
// smoothed delay straight from the target. If m_tready is low, the result
// waits in the output register; a new input beat is still accepted and is
// held in its final step until the output register frees.
`include "assert_macros.svh"

module fractional_delay_comb_filter #(
  parameter int LINE_LENGTH = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  // config write port
  input  logic                               cfg_we,
  input  logic [fdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fdc_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [47:0]                        s_tdata,  // sample_in[15:0], delay_scale[31:16],
                                                       // feedback_mod[47:32]
  // output stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [15:0]                        m_tdata   // sample_out[15:0]
);
  import fdc_pkg::*;

  // address, position (Q.8) and fold widths
  localparam int AW    = (LINE_LENGTH > 1) ? $clog2(LINE_LENGTH) : 1;
  localparam int PW    = AW + 8;
  localparam int SPAN  = LINE_LENGTH * 256;
  localparam int CW    = (PW + 1 > DELAY_W + 1) ? PW + 1 : DELAY_W + 1;
  // shifts needed so that SPAN << MOD_K covers any 20-bit delay
  localparam int MOD_K = (SPAN >= (1 << DELAY_W)) ? 0 :
                         $clog2(((1 << DELAY_W) + SPAN - 1) / SPAN);
  localparam int KW    = (MOD_K > 0) ? $clog2(MOD_K + 1) : 1;
  localparam logic [CW-1:0] SPAN_C = CW'(SPAN);
  localparam logic [AW-1:0] LAST   = AW'(LINE_LENGTH - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_MUL1, S_SMUP, S_MUL2, S_CLAMP, S_MOD, S_POS,
    S_RDA, S_RDB, S_INT, S_MUL3, S_DLY, S_MUL4, S_WRITE
  } state_t;

  state_t state;

  // config registers
  logic        [DELAY_W-1:0]  delay_target;
  logic        [DELAY_W-1:0]  max_delay;
  logic signed [SAMPLE_W-1:0] feedback;
  logic signed [SAMPLE_W-1:0] feedback_low;
  logic signed [SAMPLE_W-1:0] feedback_high;
  logic                       comb_negative;

  // per-sample working registers
  logic signed [SAMPLE_W-1:0] x;
  logic        [15:0]         scale;
  logic signed [SAMPLE_W-1:0] fmod;
  logic        [DELAY_W-1:0]  smoothed;
  logic                       restart;
  logic        [DELAY_W-1:0]  diff;
  logic                       ge;
  logic signed [16:0]         fb;
  logic        [CW-1:0]       rem;
  logic        [KW-1:0]       k;
  logic        [AW-1:0]       idx;
  logic        [7:0]          frac;
  logic signed [SAMPLE_W-1:0] tap_a;
  logic signed [16:0]         ab;
  logic signed [SAMPLE_W-1:0] dly;
  logic signed [38:0]         prod;

  // shared multiplier operands
  logic signed [20:0] ma;
  logic signed [17:0] mb;

  // line interface
  logic                       wr_en;
  logic signed [SAMPLE_W-1:0] wr_data;
  logic        [AW-1:0]       rd_addr;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic        [AW-1:0]       wr_pos;

  // datapath helpers
  logic signed [16:0] fsum;
  logic signed [16:0] fhi;
  logic signed [16:0] flo;
  logic signed [16:0] fclamp;
  logic        [23:0] dl_full;
  logic        [CW-1:0] fold_sub;
  logic        [CW-1:0] wp256;
  logic        [CW-1:0] pos;
  logic        [AW-1:0] nxt;
  logic signed [16:0] dsum;
  logic signed [18:0] wsum;
  logic signed [16:0] osum;
  logic               out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // feedback: base + mod, high clamp first, then low clamp, then sign
  assign fsum = {feedback[15], feedback} + {fmod[15], fmod};
  assign fhi  = {feedback_high[15], feedback_high};
  assign flo  = {feedback_low[15], feedback_low};
  always_comb begin
    fclamp = fsum;
    if (fclamp > fhi) begin
      fclamp = fhi;
    end
    if (fclamp < flo) begin
      fclamp = flo;
    end
  end

  assign dl_full  = prod[35:12];
  assign fold_sub = SPAN_C << k;
  assign wp256    = CW'({wr_pos, 8'h00});
  assign pos      = (wp256 >= rem) ? (wp256 - rem) : (wp256 + SPAN_C - rem);
  assign nxt      = (idx == LAST) ? '0 : idx + AW'(1);
  assign dsum     = {tap_a[15], tap_a} + prod[24:8];
  assign wsum     = {{3{x[15]}}, x} + prod[32:14];
  assign osum     = {x[15], x} + {dly[15], dly};

  always_comb begin
    unique case (state)
      S_MUL1: begin
        ma = signed'({1'b0, diff});
        mb = signed'({1'b0, SMOOTH_COEF});
      end
      S_MUL2: begin
        ma = signed'({1'b0, smoothed});
        mb = signed'({2'b00, scale});
      end
      S_MUL3: begin
        ma = {{4{ab[16]}}, ab};
        mb = signed'({10'd0, frac});
      end
      S_MUL4, S_WRITE: begin
        ma = {{5{dly[15]}}, dly};
        mb = {fb[16], fb};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign rd_addr = (state == S_RDB) ? nxt : idx;
  assign wr_en   = (state == S_WRITE) && out_free;
  always_comb begin
    if (wsum > 19'sd32767) begin
      wr_data = 16'sh7FFF;
    end else if (wsum < -19'sd32768) begin
      wr_data = 16'sh8000;
    end else begin
      wr_data = wsum[15:0];
    end
  end

  fdc_line #(
    .LINE_LENGTH (LINE_LENGTH),
    .AW          (AW)
  ) u_line (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_pos  (wr_pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_tvalid      <= 1'b0;
      restart       <= 1'b1;
      smoothed      <= '0;
      delay_target  <= DELAY_TARGET_RST;
      max_delay     <= MAX_DELAY_RST;
      feedback      <= FEEDBACK_RST;
      feedback_low  <= FEEDBACK_LOW_RST;
      feedback_high <= FEEDBACK_HIGH_RST;
      comb_negative <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DELAY_TARGET:  delay_target  <= cfg_data;
          REG_MAX_DELAY:     max_delay     <= cfg_data;
          REG_FEEDBACK:      feedback      <= cfg_data[15:0];
          REG_FEEDBACK_LOW:  feedback_low  <= cfg_data[15:0];
          REG_FEEDBACK_HIGH: feedback_high <= cfg_data[15:0];
          REG_COMB_NEGATIVE: comb_negative <= cfg_data[0];
          default: ;
        endcase
      end

      // the final step reloads the output register itself
      if (m_tvalid && m_tready && (state != S_WRITE)) begin
        m_tvalid <= 1'b0;
      end

      prod <= ma * mb;

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            x     <= s_tdata[15:0];
            scale <= s_tdata[31:16];
            fmod  <= s_tdata[47:32];
            if (restart) begin
              smoothed <= delay_target;
              restart  <= 1'b0;
            end
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          ge    <= smoothed >= delay_target;
          diff  <= (smoothed >= delay_target) ? smoothed - delay_target
                                              : delay_target - smoothed;
          fb    <= comb_negative ? -fclamp : fclamp;
          state <= S_MUL1;
        end
        S_MUL1: state <= S_SMUP;
        S_SMUP: begin
          // magnitude truncated, so the value never crosses the target and settles on it
          smoothed <= ge ? delay_target + prod[35:16] : delay_target - prod[35:16];
          state    <= S_MUL2;
        end
        S_MUL2: state <= S_CLAMP;
        S_CLAMP: begin
          rem   <= (dl_full > {4'd0, max_delay}) ? CW'(max_delay) : CW'(dl_full);
          k     <= KW'(MOD_K);
          state <= S_MOD;
        end
        S_MOD: begin
          // restoring fold: delay mod span, one shifted span per cycle
          if (rem >= fold_sub) begin
            rem <= rem - fold_sub;
          end
          if (k == '0) begin
            state <= S_POS;
          end else begin
            k <= k - KW'(1);
          end
        end
        S_POS: begin
          idx   <= pos[PW-1:8];
          frac  <= pos[7:0];
          state <= S_RDA;
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          tap_a <= rd_data;
          state <= S_INT;
        end
        S_INT: begin
          ab    <= {rd_data[15], rd_data} - {tap_a[15], tap_a};
          state <= S_MUL3;
        end
        S_MUL3: state <= S_DLY;
        S_DLY: begin
          // a + floor((b - a) * f / 256)
          dly   <= dsum[15:0];
          state <= S_MUL4;
        end
        S_MUL4: state <= S_WRITE;
        S_WRITE: begin
          // operands held, so the product stays valid until the output
          // register frees
          if (out_free) begin
            m_tdata  <= osum[16:1];
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // one sample in flight at a time
  `ASSERT_NEXT(a_single_flight, clk, rst, s_tvalid && s_tready, !s_tready)
  // a result only appears from the final step
  `ASSERT_IMPL(a_out_from_write, clk, rst, $rose(m_tvalid), $past(state) == S_WRITE)
  // the fold leaves the delay inside the line span
  `ASSERT_IMPL(a_fold_in_span, clk, rst, state == S_POS, rem < SPAN_C)
  // read taps stay inside the line
  `ASSERT_IMPL(a_idx_in_line, clk, rst, state == S_RDA, idx <= LAST)

endmodule

>>> src/fdc_line.sv
// Circular delay line: one write port, one registered read port.
// Entries not yet written since reset read as zero, tracked by the
// sequential write pointer plus a wrapped flag.
module fdc_line #(
  parameter int LINE_LENGTH = 4096,
  parameter int AW          = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic signed [fdc_pkg::SAMPLE_W-1:0]   wr_data,
  input  logic        [AW-1:0]                  rd_addr,
  output logic signed [fdc_pkg::SAMPLE_W-1:0]   rd_data,
  output logic        [AW-1:0]                  wr_pos
);
  import fdc_pkg::*;

  localparam logic [AW-1:0] LAST = AW'(LINE_LENGTH - 1);

  logic signed [SAMPLE_W-1:0] mem [LINE_LENGTH];
  logic signed [SAMPLE_W-1:0] mem_q;
  logic                       rd_ok;
  logic                       wrapped;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_pos] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos  <= '0;
      wrapped <= 1'b0;
      rd_ok   <= 1'b0;
    end else begin
      rd_ok <= wrapped || (rd_addr < wr_pos);
      if (wr_en) begin
        if (wr_pos == LAST) begin
          wr_pos  <= '0;
          wrapped <= 1'b1;
        end else begin
          wr_pos <= wr_pos + AW'(1);
        end
      end
    end
  end

  assign rd_data = rd_ok ? mem_q : '0;

endmodule
